/* hdl/scew_pkg.sv */
// scew_pkg: shared constants, codes and types of the sector chain extent walker
// used by scew_front, scew_back and the top level sector_chain_extent_walker
package scew_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int MAX_EXTENTS = 64;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int EXT_W       = $clog2(MAX_EXTENTS + 1);
    // a walk ends after at most MAX_EXTENTS+1 runs of at most TABLE_DEPTH sectors
    localparam int CNT_W       = $clog2(TABLE_DEPTH * (MAX_EXTENTS + 1)) + 1;
    localparam int OFF_W       = 36;
    localparam int QDEPTH      = 2;
    localparam int QAW         = $clog2(QDEPTH);

    localparam logic [31:0] CHAIN_END = 32'hFFFF_FFFE;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR  = 2'd1;
    localparam logic [1:0] FUNC_LOCATE = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NEG     = 3'd1;
    localparam logic [2:0] ST_SEEN    = 3'd2;
    localparam logic [2:0] ST_LONG    = 3'd3;
    localparam logic [2:0] ST_BAD_END = 3'd4;
    localparam logic [2:0] ST_SHORT   = 3'd5;
    localparam logic [2:0] ST_RANGE   = 3'd6;
    localparam logic [2:0] ST_MANY    = 3'd7;

    localparam logic [1:0] CFG_SSIZE  = 2'd0;
    localparam logic [1:0] CFG_BASE   = 2'd1;
    localparam logic [1:0] CFG_IGNORE = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [TBL_AW-1:0] index;
        logic [31:0]       value;     // table entry for a load, start sector for a locate
        logic [30:0]       expected;
        logic [7:0]        mark;
    } t_cmd;

    typedef struct packed {
        logic [4:0]  log2;
        logic [15:0] base;
        logic        ignore;
    } t_cfg;

endpackage

/* hdl/sector_chain_extent_walker.sv */
// sector_chain_extent_walker: top level, configuration registers and the two halves
// depends on scew_pkg, scew_front and scew_back
//
// A load item (func 0) writes one sector table entry, a clear item (func 1) zeroes the
// seen-mark map, and a locate item (func 2) follows the chain from its start sector and
// returns one item per contiguous byte extent, the last one flagged and carrying the
// status; after an error status the extents already returned must be thrown away.
// The front queue holds two items. A locate passes through a start state and then,
// for each sector in the chain, a table and seen-map read followed by a check that
// writes the mark; the walker also waits while the result register waits on
// o_out_ready. The seen map has a single write port, so a clear item, and the pass
// that follows reset, sweeps it entry by entry; input is not taken (o_in_ready low)
// during a sweep. Configuration writes are always taken (o_cfg_ready high) and must
// only happen while the block is idle.
module sector_chain_extent_walker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [11:0] i_entry_index,
    input  logic [31:0] i_entry_value,
    input  logic [31:0] i_start_sector,
    input  logic [30:0] i_expected_size,
    input  logic [7:0]  i_mark,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [35:0] o_extent_start,
    output logic [35:0] o_extent_end,
    output logic [2:0]  o_status,
    output logic        o_last
);
    import scew_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid, cmd_pop, clearing;

    assign o_cfg_ready = 1'b1;

    // register file: sector size log2, base offset, ignore-corruption flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.log2   <= 5'd9;
            r_cfg.base   <= 16'd512;
            r_cfg.ignore <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SSIZE:  r_cfg.log2   <= i_cfg_data[4:0];
                CFG_BASE:   r_cfg.base   <= i_cfg_data;
                CFG_IGNORE: r_cfg.ignore <= i_cfg_data[0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    // front: accept and classify, two-entry queue
    scew_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_start_sector (i_start_sector),
        .i_expected_size(i_expected_size),
        .i_mark         (i_mark),
        .i_clearing     (clearing),
        .o_cmd          (cmd),
        .o_cmd_valid    (cmd_valid),
        .i_cmd_pop      (cmd_pop)
    );

    // back: table, seen map, chain walk and result register
    scew_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd          (cmd),
        .i_cmd_valid    (cmd_valid),
        .o_cmd_pop      (cmd_pop),
        .o_clearing     (clearing),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_extent_start (o_extent_start),
        .o_extent_end   (o_extent_end),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule

/* hdl/scew_front.sv */
// scew_front: accepts input items, drops those with no effect, queues the rest
// depends on scew_pkg
module scew_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_func,
    input  logic [11:0]   i_entry_index,
    input  logic [31:0]   i_entry_value,
    input  logic [31:0]   i_start_sector,
    input  logic [30:0]   i_expected_size,
    input  logic [7:0]    i_mark,
    input  logic          i_clearing,
    output scew_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop
);
    import scew_pkg::*;

    t_cmd             r_q [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;
    logic             accept, keep, pop;
    t_cmd             cmd_in;

    assign o_in_ready  = (r_cnt != (QAW+1)'(QDEPTH)) && !i_clearing;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign pop         = i_cmd_pop && o_cmd_valid;

    // func 3 and loads past the table end have no effect
    always_comb begin
        keep = 1'b0;
        if (i_func == FUNC_LOAD) begin
            keep = ({20'b0, i_entry_index} < 32'(TABLE_DEPTH));
        end else if (i_func == FUNC_CLEAR || i_func == FUNC_LOCATE) begin
            keep = 1'b1;
        end
        cmd_in.func     = i_func;
        cmd_in.index    = TBL_AW'(i_entry_index);
        cmd_in.value    = (i_func == FUNC_LOAD) ? i_entry_value : i_start_sector;
        cmd_in.expected = i_expected_size;
        cmd_in.mark     = i_mark;
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_q[r_wp] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept && keep) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(accept && keep) - (QAW+1)'(pop);
        end
    end

endmodule

/* hdl/scew_back.sv */
// scew_back: sector table, seen map, chain walker and result register
// depends on scew_pkg
module scew_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  scew_pkg::t_cfg i_cfg,
    input  scew_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    output logic           o_clearing,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [35:0]    o_extent_start,
    output logic [35:0]    o_extent_end,
    output logic [2:0]     o_status,
    output logic           o_last
);
    import scew_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_NEXT  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;

    logic [31:0] tbl_mem  [TABLE_DEPTH];
    logic [7:0]  seen_mem [TABLE_DEPTH];

    logic [2:0]        r_state;
    logic [TBL_AW-1:0] r_clr_addr;
    logic [31:0]       r_cur;
    logic [TBL_AW-1:0] r_prev;
    logic              r_have_prev;
    logic [OFF_W-1:0]  r_run_start, r_run_end, r_ssize;
    logic [CNT_W-1:0]  r_cnt;
    logic [EXT_W-1:0]  r_ext;
    logic [32:0]       r_limit;
    logic [30:0]       r_exp;
    logic [7:0]        r_mark;
    logic [31:0]       r_tbl_q;
    logic [7:0]        r_seen_q;
    logic              r_ov, r_o_last;
    logic [OFF_W-1:0]  r_o_start, r_o_end;
    logic [2:0]        r_o_status;

    logic              out_free;
    logic              emit, fire;
    logic [OFF_W-1:0]  e_start, e_end;
    logic [2:0]        e_status;
    logic              e_last;
    logic [TBL_AW-1:0] cur_idx;
    logic              seen_err, long_err, consec, many_err;
    logic [CNT_W-1:0]  cnt_inc;
    logic [OFF_W-1:0]  new_start;
    logic [32:0]       limit_calc;

    assign out_free   = !r_ov || i_out_ready;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid;
    assign cur_idx    = r_cur[TBL_AW-1:0];

    assign cnt_inc    = r_cnt + 1'b1;
    assign seen_err   = (r_seen_q != 8'd0) && !i_cfg.ignore;
    assign long_err   = {{(33-CNT_W){1'b0}}, cnt_inc} > r_limit;
    assign consec     = r_have_prev && ({1'b0, cur_idx} == ({1'b0, r_prev} + 1'b1));
    assign many_err   = r_have_prev && !consec && (r_ext >= EXT_W'(MAX_EXTENTS));
    assign new_start  = {20'b0, i_cfg.base} + (OFF_W'(cur_idx) << i_cfg.log2);
    assign limit_calc = (33'(r_exp) + (33'(1) << i_cfg.log2) - 33'(1)) >> i_cfg.log2;

    // what the current state wants to send, and whether its step completes
    always_comb begin
        emit     = 1'b0;
        e_start  = '0;
        e_end    = '0;
        e_status = ST_OK;
        e_last   = 1'b1;
        unique case (r_state)
            S_START: begin
                emit     = r_cur[31];
                e_status = ST_NEG;
            end
            S_NEXT: begin
                if (r_cur[31]) begin
                    emit = 1'b1;
                    if (r_cur != CHAIN_END) begin
                        e_status = ST_BAD_END;
                    end else if ({{(33-CNT_W){1'b0}}, r_cnt} != r_limit) begin
                        e_status = ST_SHORT;
                    end else begin
                        e_start = r_run_start;
                        e_end   = r_run_end;
                    end
                end else if (r_cur >= 32'(TABLE_DEPTH)) begin
                    emit     = 1'b1;
                    e_status = ST_RANGE;
                end
            end
            S_EVAL: begin
                priority if (seen_err) begin
                    emit     = 1'b1;
                    e_status = ST_SEEN;
                end else if (long_err) begin
                    emit     = 1'b1;
                    e_status = ST_LONG;
                end else if (consec) begin
                    emit = 1'b0;
                end else if (many_err) begin
                    emit     = 1'b1;
                    e_status = ST_MANY;
                end else if (r_have_prev) begin
                    emit    = 1'b1;
                    e_start = r_run_start;
                    e_end   = r_run_end;
                    e_last  = 1'b0;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        fire = !emit || out_free;
    end

    // memories
    always_ff @(posedge i_clk) begin
        r_tbl_q  <= tbl_mem[cur_idx];
        r_seen_q <= seen_mem[cur_idx];
        if (o_cmd_pop && i_cmd.func == FUNC_LOAD) begin
            tbl_mem[i_cmd.index] <= i_cmd.value;
        end
        if (r_state == S_CLEAR) begin
            seen_mem[r_clr_addr] <= 8'd0;
        end else if (r_state == S_EVAL && fire && !seen_err) begin
            seen_mem[cur_idx] <= r_mark;
        end
    end

    // walker datapath
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.func == FUNC_LOCATE) begin
            r_cur  <= i_cmd.value;
            r_exp  <= i_cmd.expected;
            r_mark <= i_cmd.mark;
        end
        if (r_state == S_START) begin
            r_limit     <= limit_calc;
            r_ssize     <= OFF_W'(1) << i_cfg.log2;
            r_cnt       <= '0;
            r_ext       <= '0;
            r_have_prev <= 1'b0;
        end
        if (r_state == S_EVAL && fire && !seen_err && !long_err && !many_err) begin
            if (consec) begin
                r_run_end <= r_run_end + r_ssize;
            end else begin
                r_ext       <= r_ext + 1'b1;
                r_run_start <= new_start;
                r_run_end   <= new_start + r_ssize;
            end
            r_cnt       <= cnt_inc;
            r_prev      <= cur_idx;
            r_have_prev <= 1'b1;
            r_cur       <= r_tbl_q;
        end
        if (emit && fire) begin
            r_o_start  <= e_start;
            r_o_end    <= e_end;
            r_o_status <= e_status;
            r_o_last   <= e_last;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (emit && fire) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == TBL_AW'(TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        if (i_cmd.func == FUNC_CLEAR) begin
                            r_clr_addr <= '0;
                            r_state    <= S_CLEAR;
                        end else if (i_cmd.func == FUNC_LOCATE) begin
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    if (fire) begin
                        r_state <= emit ? S_IDLE : S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (fire) begin
                        r_state <= emit ? S_IDLE : S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (fire) begin
                        r_state <= (seen_err || long_err || many_err) ? S_IDLE : S_NEXT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_ov;
    assign o_extent_start = r_o_start;
    assign o_extent_end   = r_o_end;
    assign o_status       = r_o_status;
    assign o_last         = r_o_last;

    a_ext_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT || r_state == S_EVAL) |-> (r_ext <= EXT_W'(MAX_EXTENTS)))
        else $error("extent count beyond limit");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_status != ST_OK) |-> r_o_last)
        else $error("error result not final");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_status != ST_OK) |-> (r_o_start == '0 && r_o_end == '0))
        else $error("error result carries an extent");

    a_eval_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> ($past(r_state) == S_NEXT || $past(r_state) == S_EVAL))
        else $error("sector evaluated without a table read");

endmodule
